FILE: rtl/core/cbf_pkg.sv
// Shared types, constants and helper functions of the circuit breaker.
`timescale 1ns / 1ps
`default_nettype none

package cbf_pkg;

  localparam int CNT_W     = 32;
  localparam int CFG_W     = 32;
  localparam int TIME_W    = 64;
  localparam int SPAN_W    = 52;
  localparam int NS_PER_MS = 1000000;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HALF   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ACT_ALLOW       = 3'd0,
    ACT_SUCCESS     = 3'd1,
    ACT_FAILURE     = 3'd2,
    ACT_FORCE_OPEN  = 3'd3,
    ACT_FORCE_HALF  = 3'd4,
    ACT_FORCE_CLOSE = 3'd5,
    ACT_RESET       = 3'd6
  } act_t;

  typedef enum logic [1:0] {
    REG_FAIL_LIMIT   = 2'd0,
    REG_SUCC_LIMIT   = 2'd1,
    REG_OPEN_TIMEOUT = 2'd2,
    REG_WINDOW_LEN   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0]  fail_limit;
    logic [CFG_W-1:0]  succ_limit;
    logic [SPAN_W-1:0] open_span;
    logic [SPAN_W-1:0] window_span;
  } cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [CNT_W-1:0]  fail;
    logic [CNT_W-1:0]  succ;
    logic [CNT_W-1:0]  req;
    logic [CNT_W-1:0]  opened;
    logic [CNT_W-1:0]  rejected;
    logic [TIME_W-1:0] window_begin;
    logic [TIME_W-1:0] open_time;
  } brk_state_t;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  // true once now has reached base + span; a deadline past the time range never fires
  function automatic logic reached(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] base,
                                   input logic [SPAN_W-1:0] span);
    logic [TIME_W:0] sum;
    sum = {1'b0, base} + {{(TIME_W + 1 - SPAN_W){1'b0}}, span};
    return !sum[TIME_W] && (now >= sum[TIME_W-1:0]);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cbf_step.sv
// Next-state and verdict logic of the breaker for one event.
`timescale 1ns / 1ps
`default_nettype none

module cbf_step
  import cbf_pkg::*;
(
  input  brk_state_t        st,
  input  cfg_t              cfg,
  input  act_t              action,
  input  logic [TIME_W-1:0] now,
  output brk_state_t        st_nxt,
  output logic              verdict
);

  logic              win_fresh;
  logic              win_roll;
  logic              open_due;
  logic [CNT_W-1:0]  wc_fail;
  logic [CNT_W-1:0]  wc_succ;
  logic [CNT_W-1:0]  wc_req;
  logic [TIME_W-1:0] wc_wb;
  logic [CNT_W-1:0]  fail_inc;
  logic [CNT_W-1:0]  succ_inc;

  assign win_fresh = (st.window_begin == '0);
  assign win_roll  = !win_fresh && reached(now, st.window_begin, cfg.window_span);
  assign open_due  = reached(now, st.open_time, cfg.open_span);
  assign wc_fail   = win_roll ? '0 : st.fail;
  assign wc_succ   = win_roll ? '0 : st.succ;
  assign wc_req    = win_roll ? '0 : st.req;
  assign wc_wb     = (win_fresh || win_roll) ? now : st.window_begin;
  assign fail_inc  = bump(wc_fail);
  assign succ_inc  = bump(st.succ);

  always_comb begin
    st_nxt  = st;
    verdict = 1'b0;
    unique case (action)
      ACT_ALLOW: begin
        unique case (st.mode)
          MODE_CLOSED: begin
            st_nxt.fail         = wc_fail;
            st_nxt.succ         = wc_succ;
            st_nxt.req          = wc_req;
            st_nxt.window_begin = wc_wb;
          end
          MODE_OPEN: begin
            if (open_due) begin
              st_nxt.mode = MODE_HALF;
              st_nxt.fail = '0;
              st_nxt.succ = '0;
            end else begin
              st_nxt.rejected = bump(st.rejected);
              verdict         = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ACT_SUCCESS: begin
        unique case (st.mode)
          MODE_CLOSED: begin
            st_nxt.fail         = wc_fail;
            st_nxt.succ         = wc_succ;
            st_nxt.req          = bump(wc_req);
            st_nxt.window_begin = wc_wb;
          end
          MODE_HALF: begin
            if (succ_inc >= cfg.succ_limit) begin
              st_nxt.mode         = MODE_CLOSED;
              st_nxt.fail         = '0;
              st_nxt.succ         = '0;
              st_nxt.window_begin = now;
            end else begin
              st_nxt.succ = succ_inc;
            end
          end
          default: ;
        endcase
      end
      ACT_FAILURE: begin
        st_nxt.fail         = fail_inc;
        st_nxt.succ         = wc_succ;
        st_nxt.req          = bump(wc_req);
        st_nxt.window_begin = wc_wb;
        unique case (st.mode)
          MODE_CLOSED: begin
            if (fail_inc >= cfg.fail_limit) begin
              st_nxt.mode      = MODE_OPEN;
              st_nxt.open_time = now;
              st_nxt.opened    = bump(st.opened);
            end
          end
          MODE_HALF: begin
            st_nxt.mode      = MODE_OPEN;
            st_nxt.open_time = now;
            st_nxt.opened    = bump(st.opened);
            st_nxt.succ      = '0;
          end
          default: ;
        endcase
      end
      ACT_FORCE_OPEN: begin
        st_nxt.mode      = MODE_OPEN;
        st_nxt.open_time = now;
        st_nxt.opened    = bump(st.opened);
      end
      ACT_FORCE_HALF: begin
        st_nxt.mode = MODE_HALF;
        st_nxt.fail = '0;
        st_nxt.succ = '0;
      end
      ACT_FORCE_CLOSE: begin
        st_nxt.mode         = MODE_CLOSED;
        st_nxt.fail         = '0;
        st_nxt.succ         = '0;
        st_nxt.window_begin = '0;
      end
      ACT_RESET: begin
        st_nxt.mode         = MODE_CLOSED;
        st_nxt.fail         = '0;
        st_nxt.succ         = '0;
        st_nxt.req          = '0;
        st_nxt.open_time    = '0;
        st_nxt.window_begin = '0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/circuit_breaker_fsm.sv
// Circuit breaker top level: input register, breaker state, result register.
//
// Closed/open/half-open circuit breaker driven by timestamped events. Each
// accepted transaction yields exactly one result transaction. An event waits
// in the input register, is evaluated against the breaker state by a single
// pass of compare and counter logic, and lands in the result register while
// the state updates, so the block sustains one event per clock cycle while
// out_ready does not hold back a pending result. The time spans are
// converted from milliseconds to nanoseconds by a multiplier on the
// configuration write path, so a register write takes effect for the next
// event. Counters saturate at all ones.
`timescale 1ns / 1ps
`default_nettype none

module circuit_breaker_fsm
  import cbf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_action,
  input  logic [TIME_W-1:0] in_now_time_ns,

  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_verdict,
  output logic [1:0]        out_mode_after,
  output logic [CNT_W-1:0]  out_fail_total,
  output logic [CNT_W-1:0]  out_succ_total,
  output logic [CNT_W-1:0]  out_request_count,
  output logic [CNT_W-1:0]  out_open_count,
  output logic [CNT_W-1:0]  out_reject_count
);

  localparam logic [CFG_W-1:0] RST_FAIL_LIMIT = CFG_W'(5);
  localparam logic [CFG_W-1:0] RST_SUCC_LIMIT = CFG_W'(2);
  localparam logic [SPAN_W-1:0] RST_OPEN_SPAN = SPAN_W'(64'd30000 * NS_PER_MS);
  localparam logic [SPAN_W-1:0] RST_WIN_SPAN  = SPAN_W'(64'd60000 * NS_PER_MS);

  cfg_t              cfg_r;
  logic [SPAN_W-1:0] wr_span;

  brk_state_t        st_r;
  brk_state_t        st_nxt;

  logic              in_v_r;
  act_t              act_r;
  logic [TIME_W-1:0] now_r;

  logic              out_v_r;
  logic              verdict_r;
  mode_t             mode_r;
  logic [CNT_W-1:0]  fail_r;
  logic [CNT_W-1:0]  succ_r;
  logic [CNT_W-1:0]  req_r;
  logic [CNT_W-1:0]  opened_r;
  logic [CNT_W-1:0]  rejected_r;

  logic              verdict_nxt;
  logic              advance;

  assign wr_span  = {{(SPAN_W - CFG_W){1'b0}}, cfg_wdata} * SPAN_W'(NS_PER_MS);
  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  cbf_step u_step (
    .st      (st_r),
    .cfg     (cfg_r),
    .action  (act_r),
    .now     (now_r),
    .st_nxt  (st_nxt),
    .verdict (verdict_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fail_limit  <= RST_FAIL_LIMIT;
      cfg_r.succ_limit  <= RST_SUCC_LIMIT;
      cfg_r.open_span   <= RST_OPEN_SPAN;
      cfg_r.window_span <= RST_WIN_SPAN;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FAIL_LIMIT:   cfg_r.fail_limit  <= cfg_wdata;
        REG_SUCC_LIMIT:   cfg_r.succ_limit  <= cfg_wdata;
        REG_OPEN_TIMEOUT: cfg_r.open_span   <= wr_span;
        REG_WINDOW_LEN:   cfg_r.window_span <= wr_span;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= '{mode: MODE_CLOSED, default: '0};
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        st_r    <= st_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      act_r <= act_t'(in_action);
      now_r <= in_now_time_ns;
    end
    if (advance) begin
      verdict_r  <= verdict_nxt;
      mode_r     <= st_nxt.mode;
      fail_r     <= st_nxt.fail;
      succ_r     <= st_nxt.succ;
      req_r      <= st_nxt.req;
      opened_r   <= st_nxt.opened;
      rejected_r <= st_nxt.rejected;
    end
  end

  assign out_valid         = out_v_r;
  assign out_verdict       = verdict_r;
  assign out_mode_after    = mode_r;
  assign out_fail_total    = fail_r;
  assign out_succ_total    = succ_r;
  assign out_request_count = req_r;
  assign out_open_count    = opened_r;
  assign out_reject_count  = rejected_r;

  a_refuse_only_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict |-> out_mode_after == MODE_OPEN && out_reject_count != '0)
    else $error("refusal reported outside open state");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_v_r && out_v_r && !out_ready)
    else $error("input stalled with room downstream");

  a_opened_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> st_r.opened >= $past(st_r.opened))
    else $error("open counter went backwards");

  a_state_moves_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(advance) |-> $stable(st_r))
    else $error("breaker state changed without a transaction");

endmodule

`default_nettype wire
